FILE: sv/nts_pkg.sv
package nts_pkg;

  // Table geometry and field widths.
  localparam int MAX_VARS   = 64;
  localparam int MAX_DOMAIN = 16;
  localparam int HEUR_WIDTH = 16;

  localparam int TABLE_DEPTH = MAX_VARS * MAX_DOMAIN;
  localparam int TABLE_AW    = $clog2(TABLE_DEPTH);

  localparam int CNT_W     = 7;
  localparam int NV_W      = 7;
  localparam int SCORE_W   = 8;
  localparam int VAR_W     = 6;
  localparam int VAL_W     = 4;
  localparam int HEUR_IN_W = 16;

  localparam logic [CNT_W-1:0]      COUNT_MAX = '1;
  localparam logic [SCORE_W-1:0]    SCORE_MAX = '1;
  localparam logic [HEUR_WIDTH-1:0] HEUR_MAX  = '1;
  localparam logic [NV_W-1:0]       NV_MAX    = NV_W'(MAX_VARS);
  localparam logic [NV_W-1:0]       NV_RESET  = NV_W'(1);

  // Input word: one state variable of a search state.
  typedef struct packed {
    logic [VAR_W-1:0]     var_index;
    logic [VAL_W-1:0]     fact_value;
    logic [HEUR_IN_W-1:0] heur_value;
    logic                 heur_dead_end;
    logic                 is_last;
  } in_word_t;

  // Output word: the score of one finished state.
  typedef struct packed {
    logic [SCORE_W-1:0] novelty_score;
    logic               is_dead;
  } out_word_t;

  // One table entry: seen flag and best heuristic value so far.
  typedef struct packed {
    logic                  seen;
    logic [HEUR_WIDTH-1:0] heur;
  } entry_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clear;
    logic accept;
    logic update;
    logic finish;
  } nts_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clear_last;
    logic item_last;
    logic out_free;
  } nts_status_t;

  // Saturate an incoming heuristic value to the stored width.
  function automatic logic [HEUR_WIDTH-1:0] sat_heur(input logic [HEUR_IN_W-1:0] v);
    logic [HEUR_WIDTH-1:0] r;
    if (32'(v) > 32'(HEUR_MAX)) r = HEUR_MAX;
    else r = HEUR_WIDTH'(v);
    return r;
  endfunction

endpackage

FILE: sv/novelty_table_scorer.sv
// A word is accepted and the table is read when it is accepted; the table is updated in the
// next cycle, and on the last word of a state the score word is registered in a finish state.
// The controller takes a word only while idle: it reads the table when it takes a word and
// writes it back in the next cycle before it takes another; a held score word keeps it in
// the finish state after the last word of a state.
// Reset: synchronous; the 1024-entry table is swept clear entry by entry after reset, during
// which no word is accepted. num_vars resets to 1.
module novelty_table_scorer import nts_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  in_word_t        in_word,
  output logic            out_valid,
  input  logic            out_ready,
  output out_word_t       out_word,
  input  logic            cfg_valid,
  output logic            cfg_ready,
  input  logic [NV_W-1:0] cfg_data
);

  nts_cmd_t    cmd;
  nts_status_t status;

  // Configuration is always taken.
  assign cfg_ready = 1'b1;

  nts_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  nts_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .in_word   (in_word),
    .out_word  (out_word),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .status    (status)
  );

endmodule

FILE: sv/nts_ctrl.sv
module nts_ctrl import nts_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  nts_status_t status,
  output nts_cmd_t    cmd
);

  typedef enum logic [3:0] {
    S_CLEAR  = 4'b0001,
    S_IDLE   = 4'b0010,
    S_UPDATE = 4'b0100,
    S_FINISH = 4'b1000
  } state_t;

  state_t state, state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) state <= S_CLEAR;
    else state <= state_next;
  end

  // Next state and commands.
  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      S_CLEAR: begin
        cmd.clear = 1'b1;
        if (status.clear_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_next = S_UPDATE;
        end
      end
      S_UPDATE: begin
        cmd.update = 1'b1;
        state_next = status.item_last ? S_FINISH : S_IDLE;
      end
      S_FINISH: begin
        if (status.out_free) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_CLEAR;
    endcase
  end

endmodule

FILE: sv/nts_datapath.sv
module nts_datapath import nts_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  in_word_t        in_word,
  output out_word_t       out_word,
  output logic            out_valid,
  input  logic            out_ready,
  input  logic            cfg_valid,
  input  logic [NV_W-1:0] cfg_data,
  input  nts_cmd_t        cmd,
  output nts_status_t     status
);

  entry_t mem [TABLE_DEPTH];
  entry_t rd_entry;

  logic [TABLE_AW-1:0]   clr_addr;
  logic [NV_W-1:0]       num_vars;
  logic [NV_W-1:0]       eff_vars;
  logic [CNT_W-1:0]      better_count;
  logic [CNT_W-1:0]      worse_count;
  logic                  state_dead;

  // Latched item.
  logic [TABLE_AW-1:0]   item_addr;
  logic [HEUR_WIDTH-1:0] item_heur;
  logic                  item_hit;
  logic                  item_dead;
  logic                  item_last;

  logic [TABLE_AW-1:0]   in_addr;
  logic                  in_hit;
  logic                  is_better;
  logic                  is_worse;
  logic [SCORE_W-1:0]    score;

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) num_vars <= NV_RESET;
    else if (cfg_valid) num_vars <= cfg_data;
  end

  assign eff_vars = (num_vars > NV_MAX) ? NV_MAX : num_vars;

  // Address and range check of the incoming word.
  assign in_addr = TABLE_AW'(in_word.var_index) * TABLE_AW'(MAX_DOMAIN)
                 + TABLE_AW'(in_word.fact_value);
  assign in_hit  = !in_word.heur_dead_end
                && ({1'b0, in_word.var_index} < eff_vars)
                && (32'(in_word.fact_value) < MAX_DOMAIN);

  // Latch the item when it is accepted.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      item_addr <= in_addr;
      item_heur <= sat_heur(in_word.heur_value);
      item_hit  <= in_hit;
      item_dead <= in_word.heur_dead_end;
      item_last <= in_word.is_last;
    end
  end

  // Compare the stored entry against the item's value.
  assign is_better = item_hit && (!rd_entry.seen || (rd_entry.heur > item_heur));
  assign is_worse  = item_hit && rd_entry.seen && (rd_entry.heur < item_heur);

  // Clear sweep address.
  always_ff @(posedge clk) begin
    if (rst) clr_addr <= '0;
    else if (cmd.clear) clr_addr <= clr_addr + TABLE_AW'(1);
  end

  // Best-seen table: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (cmd.clear) mem[clr_addr] <= '0;
    else if (cmd.update && is_better) mem[item_addr] <= '{seen: 1'b1, heur: item_heur};
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) rd_entry <= mem[in_addr];
  end

  // Per-state counters and sticky dead-end flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      better_count <= '0;
      worse_count  <= '0;
      state_dead   <= 1'b0;
    end else if (cmd.finish) begin
      better_count <= '0;
      worse_count  <= '0;
      state_dead   <= 1'b0;
    end else if (cmd.update) begin
      if (item_dead) state_dead <= 1'b1;
      if (is_better && better_count != COUNT_MAX) better_count <= better_count + CNT_W'(1);
      if (is_worse && worse_count != COUNT_MAX) worse_count <= worse_count + CNT_W'(1);
    end
  end

  // Score of the finished state.
  always_comb begin
    logic [SCORE_W:0] sum;
    sum = '0;
    if (better_count != '0) begin
      if (better_count > eff_vars) sum = '0;
      else sum = (SCORE_W+1)'(eff_vars - better_count);
    end else begin
      sum = (SCORE_W+1)'(eff_vars) + (SCORE_W+1)'(worse_count);
    end
    score = (sum > (SCORE_W+1)'(SCORE_MAX)) ? SCORE_MAX : sum[SCORE_W-1:0];
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (cmd.finish) out_valid <= 1'b1;
    else if (out_ready) out_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_word.is_dead       <= state_dead;
      out_word.novelty_score <= state_dead ? '0 : score;
    end
  end

  assign status.clear_last = (32'(clr_addr) == TABLE_DEPTH - 1);
  assign status.item_last  = item_last;
  assign status.out_free   = !out_valid || out_ready;

endmodule

FILE: tb/nts_score_checker.sv
module nts_score_checker import nts_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  input  logic            in_ready,
  input  in_word_t        in_word,
  input  logic            out_valid,
  input  logic            out_ready,
  input  out_word_t       out_word,
  input  logic            cfg_valid,
  input  logic            cfg_ready,
  input  logic [NV_W-1:0] cfg_data,
  output int              pending,
  output int              fail_count
);

  // Shadow copy of the block's state.
  logic                  seen_map  [TABLE_DEPTH];
  logic [HEUR_WIDTH-1:0] best_heur [TABLE_DEPTH];
  logic [CNT_W-1:0]      better_cnt;
  logic [CNT_W-1:0]      worse_cnt;
  logic                  dead_seen;
  logic [NV_W-1:0]       num_vars_q;

  // Scores expected from the block, oldest first.
  out_word_t score_q[$];

  // Fold one accepted word into the shadow table. Returns 1 when the word ends a
  // state, with the score word that the block must produce for it.
  function automatic bit score_word(input in_word_t w, output out_word_t r);
    logic [HEUR_WIDTH-1:0] h;
    logic [NV_W-1:0]       nv;
    int                    idx;
    int                    score;
    h  = (32'(w.heur_value) > 32'(HEUR_MAX)) ? HEUR_MAX : HEUR_WIDTH'(w.heur_value);
    nv = (num_vars_q > NV_MAX) ? NV_MAX : num_vars_q;
    r  = '0;
    if (w.heur_dead_end) begin
      dead_seen = 1'b1;
    end
    // Only a live word with a variable and value in range touches the table.
    if (!w.heur_dead_end && NV_W'(w.var_index) < nv && int'(w.fact_value) < MAX_DOMAIN) begin
      idx = int'(w.var_index) * MAX_DOMAIN + int'(w.fact_value);
      if (!seen_map[idx] || best_heur[idx] > h) begin
        seen_map[idx]  = 1'b1;
        best_heur[idx] = h;
        if (better_cnt != COUNT_MAX) better_cnt = better_cnt + CNT_W'(1);
      end else if (best_heur[idx] < h) begin
        if (worse_cnt != COUNT_MAX) worse_cnt = worse_cnt + CNT_W'(1);
      end
    end
    if (!w.is_last) return 1'b0;
    // The last word of a state yields the score and starts a fresh state.
    if (dead_seen) begin
      r.is_dead = 1'b1;
      score = 0;
    end else if (better_cnt != '0) begin
      score = (int'(better_cnt) > int'(nv)) ? 0 : int'(nv) - int'(better_cnt);
    end else begin
      score = int'(nv) + int'(worse_cnt);
    end
    if (score > int'(SCORE_MAX)) score = int'(SCORE_MAX);
    r.novelty_score = SCORE_W'(score);
    better_cnt = '0;
    worse_cnt  = '0;
    dead_seen  = 1'b0;
    return 1'b1;
  endfunction

  // Watch all three channels at each rising edge.
  always @(posedge clk) begin : watch
    out_word_t want;
    out_word_t pred;
    if (rst) begin
      for (int i = 0; i < TABLE_DEPTH; i++) begin
        seen_map[i]  = 1'b0;
        best_heur[i] = '0;
      end
      better_cnt = '0;
      worse_cnt  = '0;
      dead_seen  = 1'b0;
      num_vars_q = NV_RESET;
      score_q.delete();
      fail_count = 0;
    end else begin
      // Compare a delivered score word with the oldest expectation.
      if (out_valid && out_ready) begin
        if (score_q.size() == 0) begin
          $error("unexpected score word: novelty_score %0d, is_dead %0d",
                 out_word.novelty_score, out_word.is_dead);
          fail_count++;
        end else begin
          want = score_q.pop_front();
          if (out_word.novelty_score !== want.novelty_score) begin
            $error("novelty_score: expected %0d, actual %0d",
                   want.novelty_score, out_word.novelty_score);
            fail_count++;
          end
          if (out_word.is_dead !== want.is_dead) begin
            $error("is_dead: expected %0d, actual %0d", want.is_dead, out_word.is_dead);
            fail_count++;
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        num_vars_q = cfg_data;
      end
      if (in_valid && in_ready) begin
        if (score_word(in_word, pred)) score_q.push_back(pred);
      end
    end
    pending <= score_q.size();
  end

endmodule

FILE: tb/tb.sv
module tb;
  import nts_pkg::*;

  localparam int WORD_BUDGET  = 500;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 8;

  logic            clk = 1'b0;
  logic            rst;
  logic            in_valid;
  logic            in_ready;
  in_word_t        in_word;
  logic            out_valid;
  logic            out_ready;
  out_word_t       out_word;
  logic            cfg_valid;
  logic            cfg_ready;
  logic [NV_W-1:0] cfg_data;

  int pending;
  int fail_count;
  int words_sent;
  int cycles;
  bit no_idle;

  always #10 clk = ~clk;

  novelty_table_scorer uut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (out_word),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  nts_score_checker chk (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_word    (in_word),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_word   (out_word),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .pending    (pending),
    .fail_count (fail_count)
  );

  function automatic in_word_t make_word(input int vi, input int fv, input int hv,
                                         input bit dead, input bit last);
    in_word_t w;
    w.var_index     = VAR_W'(vi);
    w.fact_value    = VAL_W'(fv);
    w.heur_value    = HEUR_IN_W'(hv);
    w.heur_dead_end = dead;
    w.is_last       = last;
    return w;
  endfunction

  // Offer one word after a random gap, or none when no_idle is set, and hold it until it is taken.
  task automatic send_word(input in_word_t w);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    do @(posedge clk); while (!in_ready);
    words_sent++;
  endtask

  // Let every expected score arrive, then give the pipeline time to go quiet.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_num_vars(input int nv);
    cfg_valid <= 1'b1;
    cfg_data  <= NV_W'(nv);
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // Receiver side: stall for a random gap before each score word, or none when no_idle is set.
  initial begin : receiver
    int stall;
    out_ready <= 1'b0;
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 3);
      repeat (stall) begin
        out_ready <= 1'b0;
        @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid && out_ready));
    end
  end

  // Hard stop in case the block hangs.
  initial begin : watchdog
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("novelty_table_scorer regression: fail");
    $finish;
  end

  initial begin : stimulus
    int       nv;
    int       eff;
    int       len;
    int       hv;
    int       dead_at;
    int       pick;
    in_word_t w;
    rst        <= 1'b1;
    in_valid   <= 1'b0;
    in_word    <= '0;
    cfg_valid  <= 1'b0;
    cfg_data   <= '0;
    no_idle    = 1'b0;
    words_sent = 0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // One variable after reset: unseen, equal, worse, and more betters than variables.
    send_word(make_word(0, 0, 100, 1'b0, 1'b1));
    send_word(make_word(0, 0, 100, 1'b0, 1'b1));
    send_word(make_word(0, 0, 200, 1'b0, 1'b1));
    send_word(make_word(0, 0, 50, 1'b0, 1'b0));
    send_word(make_word(0, 1, 50, 1'b0, 1'b0));
    send_word(make_word(0, 2, 50, 1'b0, 1'b1));
    // Variables beyond num_vars are ignored.
    send_word(make_word(1, 0, 7, 1'b0, 1'b1));
    send_word(make_word(63, 15, 65535, 1'b0, 1'b1));
    // A dead end early in a state sticks to the whole state.
    send_word(make_word(0, 3, 0, 1'b1, 1'b0));
    send_word(make_word(0, 4, 0, 1'b0, 1'b1));
    settle();

    // Largest variable count, with the widest heuristic values.
    write_num_vars(MAX_VARS);
    send_word(make_word(63, 15, 65535, 1'b0, 1'b0));
    send_word(make_word(0, 0, 0, 1'b0, 1'b1));
    send_word(make_word(63, 15, 65534, 1'b0, 1'b1));
    settle();

    // A register value above MAX_VARS saturates.
    write_num_vars(127);
    send_word(make_word(63, 15, 65535, 1'b0, 1'b1));
    send_word(make_word(32, 8, 0, 1'b1, 1'b1));
    settle();

    // No variables: every word is ignored.
    write_num_vars(0);
    send_word(make_word(0, 0, 0, 1'b0, 1'b0));
    send_word(make_word(5, 5, 5, 1'b0, 1'b1));
    settle();

    // Long states drive both counters into saturation: fresh facts, then one repeated worse fact.
    write_num_vars(MAX_VARS);
    len = 130 + $urandom_range(0, 20);
    for (int k = 0; k < len; k++) begin
      send_word(make_word(k % 64, 8 + k / 64, $urandom_range(0, 65534), 1'b0, k == len - 1));
    end
    len = 130 + $urandom_range(0, 20);
    for (int k = 0; k < len; k++) begin
      send_word(make_word(1, 9, 65535, 1'b0, k == len - 1));
    end
    settle();

    // Random phases, each with its own variable count and idling mode.
    while (words_sent < WORD_BUDGET) begin
      pick = $urandom_range(0, 9);
      if (pick < 6) nv = $urandom_range(1, 6);
      else if (pick == 6) nv = 0;
      else if (pick == 7) nv = $urandom_range(60, 66);
      else if (pick == 8) nv = 127;
      else nv = $urandom_range(0, 127);
      write_num_vars(nv);
      no_idle = ($urandom_range(0, 3) == 0);
      eff = (nv > MAX_VARS) ? MAX_VARS : nv;
      for (int st = $urandom_range(3, 8); st > 0 && words_sent < WORD_BUDGET; st--) begin
        if ($urandom_range(0, 9) < 8) begin
          // Well-formed state: a word per variable (1-3 if none), one heuristic value throughout.
          pick = $urandom_range(0, 7);
          if (pick == 0) hv = $urandom_range(0, 65535);
          else if (pick == 1) hv = 65535;
          else if (pick == 2) hv = 0;
          else hv = $urandom_range(0, 15);
          len = (eff == 0) ? $urandom_range(1, 3) : eff;
          dead_at = ($urandom_range(0, 9) == 0) ? $urandom_range(0, len - 1) : -1;
          for (int k = 0; k < len; k++) begin
            send_word(make_word(k,
                                $urandom_range(0, 1) ? $urandom_range(0, 3)
                                                     : $urandom_range(0, 15),
                                hv, k == dead_at, k == len - 1));
          end
        end else begin
          // Noise: arbitrary words, closed by a last mark.
          len = $urandom_range(1, 6);
          for (int k = 0; k < len; k++) begin
            w = $bits(in_word_t)'($urandom);
            if (k == len - 1) w.is_last = 1'b1;
            send_word(w);
          end
        end
      end
      settle();
    end

    if (fail_count == 0) begin
      $display("novelty_table_scorer regression: pass");
    end else begin
      $display("novelty_table_scorer regression: fail");
    end
    $finish;
  end

endmodule
